// ===== hdl/bpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpsc_pkg
// Shared constants and types for the box / plane side classifier pipeline.
// ----------------------------------------------------------------------------
package bpsc_pkg;

    // Default coordinate width and the fixed binary point of every coordinate
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS      = 16;
    localparam int NUM_AXES       = 3;

    // Plane kind codes
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_AXIAL_X = 3'd0;
    localparam logic [KIND_W-1:0] KIND_AXIAL_Y = 3'd1;
    localparam logic [KIND_W-1:0] KIND_AXIAL_Z = 3'd2;

    // Side mask codes
    localparam int MASK_W = 2;
    localparam logic [MASK_W-1:0] SIDE_NONE     = 2'b00;
    localparam logic [MASK_W-1:0] SIDE_FRONT    = 2'b01;
    localparam logic [MASK_W-1:0] SIDE_BACK     = 2'b10;
    localparam logic [MASK_W-1:0] SIDE_STRADDLE = 2'b11;

    // Per-stage control: incoming valid and the stage load enable
    typedef struct packed {
        logic valid;
        logic advance;
    } t_pipe_ctl;

endpackage

// ===== hdl/bpsc_select.sv =====
// ----------------------------------------------------------------------------
// bpsc_select
// Stage 1: pick the far and near box corners from the normal sign bits and
// resolve axial planes against the box bounds on their axis.
// ----------------------------------------------------------------------------
module bpsc_select #(
    parameter int COORD_BITS = bpsc_pkg::COORD_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  bpsc_pkg::t_pipe_ctl                           i_ctl,
    input  logic [bpsc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] i_norm,
    input  logic [COORD_BITS-1:0]                         i_dist,
    input  logic [bpsc_pkg::KIND_W-1:0]                   i_kind,
    input  logic [bpsc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] i_min,
    input  logic [bpsc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] i_max,
    output logic                                          o_valid,
    output logic [bpsc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] o_norm,
    output logic [bpsc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] o_far,
    output logic [bpsc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] o_near,
    output logic [COORD_BITS-1:0]                         o_dist,
    output logic                                          o_axial,
    output logic [bpsc_pkg::MASK_W-1:0]                   o_axial_mask
);

    logic                                          r_valid;
    logic [bpsc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] r_norm;
    logic [bpsc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] r_far;
    logic [bpsc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] r_near;
    logic [COORD_BITS-1:0]                         r_dist;
    logic                                          r_axial;
    logic [bpsc_pkg::MASK_W-1:0]                   r_axial_mask;

    logic [bpsc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] n_far;
    logic [bpsc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] n_near;
    logic                                          n_axial;
    logic [bpsc_pkg::MASK_W-1:0]                   n_axial_mask;
    logic [COORD_BITS-1:0]                         w_lo;
    logic [COORD_BITS-1:0]                         w_hi;

    // Negative normal component swaps which bound is farthest along it
    always_comb begin
        for (int j = 0; j < bpsc_pkg::NUM_AXES; j++) begin
            n_far[j]  = i_norm[j][COORD_BITS-1] ? i_min[j] : i_max[j];
            n_near[j] = i_norm[j][COORD_BITS-1] ? i_max[j] : i_min[j];
        end
    end

    // Pick the bounds on the plane's axis for axial kinds
    always_comb begin
        n_axial = 1'b1;
        w_lo    = i_min[0];
        w_hi    = i_max[0];
        unique case (i_kind)
            bpsc_pkg::KIND_AXIAL_X: begin
                w_lo = i_min[0];
                w_hi = i_max[0];
            end
            bpsc_pkg::KIND_AXIAL_Y: begin
                w_lo = i_min[1];
                w_hi = i_max[1];
            end
            bpsc_pkg::KIND_AXIAL_Z: begin
                w_lo = i_min[2];
                w_hi = i_max[2];
            end
            default: begin
                n_axial = 1'b0;
            end
        endcase
    end

    // Classify against the axis bounds, lower bound first
    always_comb begin
        priority if ($signed(i_dist) <= $signed(w_lo)) begin
            n_axial_mask = bpsc_pkg::SIDE_FRONT;
        end else if ($signed(i_dist) >= $signed(w_hi)) begin
            n_axial_mask = bpsc_pkg::SIDE_BACK;
        end else begin
            n_axial_mask = bpsc_pkg::SIDE_STRADDLE;
        end
    end

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.advance) begin
            r_valid <= i_ctl.valid;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_norm       <= i_norm;
            r_far        <= n_far;
            r_near       <= n_near;
            r_dist       <= i_dist;
            r_axial      <= n_axial;
            r_axial_mask <= n_axial_mask;
        end
    end

    assign o_valid      = r_valid;
    assign o_norm       = r_norm;
    assign o_far        = r_far;
    assign o_near       = r_near;
    assign o_dist       = r_dist;
    assign o_axial      = r_axial;
    assign o_axial_mask = r_axial_mask;

endmodule

// ===== hdl/bpsc_mult.sv =====
// ----------------------------------------------------------------------------
// bpsc_mult
// Stage 2: six exact signed products, normal times far and near corners.
// ----------------------------------------------------------------------------
module bpsc_mult #(
    parameter int COORD_BITS = bpsc_pkg::COORD_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  bpsc_pkg::t_pipe_ctl                           i_ctl,
    input  logic [bpsc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] i_norm,
    input  logic [bpsc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] i_far,
    input  logic [bpsc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] i_near,
    input  logic [COORD_BITS-1:0]                         i_dist,
    input  logic                                          i_axial,
    input  logic [bpsc_pkg::MASK_W-1:0]                   i_axial_mask,
    output logic                                          o_valid,
    output logic [bpsc_pkg::NUM_AXES-1:0][2*COORD_BITS-1:0] o_far_prod,
    output logic [bpsc_pkg::NUM_AXES-1:0][2*COORD_BITS-1:0] o_near_prod,
    output logic [COORD_BITS-1:0]                         o_dist,
    output logic                                          o_axial,
    output logic [bpsc_pkg::MASK_W-1:0]                   o_axial_mask
);

    localparam int PW = 2 * COORD_BITS;

    logic                                  r_valid;
    logic [bpsc_pkg::NUM_AXES-1:0][PW-1:0] r_far_prod;
    logic [bpsc_pkg::NUM_AXES-1:0][PW-1:0] r_near_prod;
    logic [COORD_BITS-1:0]                 r_dist;
    logic                                  r_axial;
    logic [bpsc_pkg::MASK_W-1:0]           r_axial_mask;

    logic [bpsc_pkg::NUM_AXES-1:0][PW-1:0] n_far_prod;
    logic [bpsc_pkg::NUM_AXES-1:0][PW-1:0] n_near_prod;

    // One multiplier per product, full width so nothing is lost
    always_comb begin
        for (int j = 0; j < bpsc_pkg::NUM_AXES; j++) begin
            n_far_prod[j]  = PW'($signed(i_norm[j]) * $signed(i_far[j]));
            n_near_prod[j] = PW'($signed(i_norm[j]) * $signed(i_near[j]));
        end
    end

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.advance) begin
            r_valid <= i_ctl.valid;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_far_prod   <= n_far_prod;
            r_near_prod  <= n_near_prod;
            r_dist       <= i_dist;
            r_axial      <= i_axial;
            r_axial_mask <= i_axial_mask;
        end
    end

    assign o_valid      = r_valid;
    assign o_far_prod   = r_far_prod;
    assign o_near_prod  = r_near_prod;
    assign o_dist       = r_dist;
    assign o_axial      = r_axial;
    assign o_axial_mask = r_axial_mask;

endmodule

// ===== hdl/bpsc_reduce.sv =====
// ----------------------------------------------------------------------------
// bpsc_reduce
// Stages 3 and 4: sum the products into far and near dot products, then
// compare both with the scaled plane distance and register the side mask.
// ----------------------------------------------------------------------------
module bpsc_reduce #(
    parameter int COORD_BITS = bpsc_pkg::COORD_BITS_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  bpsc_pkg::t_pipe_ctl                             i_ctl_sum,
    input  bpsc_pkg::t_pipe_ctl                             i_ctl_out,
    input  logic [bpsc_pkg::NUM_AXES-1:0][2*COORD_BITS-1:0] i_far_prod,
    input  logic [bpsc_pkg::NUM_AXES-1:0][2*COORD_BITS-1:0] i_near_prod,
    input  logic [COORD_BITS-1:0]                           i_dist,
    input  logic                                            i_axial,
    input  logic [bpsc_pkg::MASK_W-1:0]                     i_axial_mask,
    output logic                                            o_sum_valid,
    output logic                                            o_valid,
    output logic [bpsc_pkg::MASK_W-1:0]                     o_mask
);

    localparam int SW = 2 * COORD_BITS + 2;

    logic                        r_sum_valid;
    logic signed [SW-1:0]        r_far_sum;
    logic signed [SW-1:0]        r_near_sum;
    logic signed [SW-1:0]        r_dist_w;
    logic                        r_axial;
    logic [bpsc_pkg::MASK_W-1:0] r_axial_mask;
    logic                        r_valid;
    logic [bpsc_pkg::MASK_W-1:0] r_mask;

    logic signed [SW-1:0]        n_far_sum;
    logic signed [SW-1:0]        n_near_sum;
    logic signed [SW-1:0]        n_dist_w;
    logic [bpsc_pkg::MASK_W-1:0] n_mask;

    // Three-term sums, sign extended so no carry is lost
    always_comb begin
        n_far_sum  = '0;
        n_near_sum = '0;
        for (int j = 0; j < bpsc_pkg::NUM_AXES; j++) begin
            n_far_sum  = n_far_sum + SW'($signed(i_far_prod[j]));
            n_near_sum = n_near_sum + SW'($signed(i_near_prod[j]));
        end
        n_dist_w = SW'($signed(i_dist)) <<< bpsc_pkg::FRAC_BITS;
    end

    // Front if far reaches the plane, back if near falls short of it; axial kinds keep their stage 1 mask
    always_comb begin
        if (r_axial) begin
            n_mask = r_axial_mask;
        end else begin
            n_mask = bpsc_pkg::SIDE_NONE;
            if (r_far_sum >= r_dist_w) begin
                n_mask = n_mask | bpsc_pkg::SIDE_FRONT;
            end
            if (r_near_sum < r_dist_w) begin
                n_mask = n_mask | bpsc_pkg::SIDE_BACK;
            end
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            if (i_ctl_sum.advance) begin
                r_sum_valid <= i_ctl_sum.valid;
            end
            if (i_ctl_out.advance) begin
                r_valid <= i_ctl_out.valid;
            end
        end
    end

    // Sum stage payload
    always_ff @(posedge i_clk) begin
        if (i_ctl_sum.advance) begin
            r_far_sum    <= n_far_sum;
            r_near_sum   <= n_near_sum;
            r_dist_w     <= n_dist_w;
            r_axial      <= i_axial;
            r_axial_mask <= i_axial_mask;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_ctl_out.advance) begin
            r_mask <= n_mask;
        end
    end

    assign o_sum_valid = r_sum_valid;
    assign o_valid     = r_valid;
    assign o_mask      = r_mask;

endmodule

// ===== hdl/box_plane_side_classifier.sv =====
// An input beat passes through four register stages (select, multiply, sum,
// compare), the first loaded at the edge that accepts it, to the master side.
// Throughput: one beat per cycle while the output is not stalled; set by the
// four-stage pipeline, each stage loading whenever it is empty or drains.
// A stalled output holds a full stage only if every stage after it is full.
// Reset (synchronous, active low) clears only the stage valid bits.
// ----------------------------------------------------------------------------
// box_plane_side_classifier
// Classifies an axis-aligned box against a plane: front, back or straddling.
// ----------------------------------------------------------------------------
module box_plane_side_classifier #(
    parameter int COORD_BITS = bpsc_pkg::COORD_BITS_DEF,
    parameter int IN_W       = ((10 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // normal_x, normal_y, normal_z, plane_dist, min_x, min_y, min_z,
    // max_x, max_y, max_z (COORD_BITS each), zero padding
    input  logic [IN_W-1:0]             s_axis_tdata,
    // plane_kind
    input  logic [bpsc_pkg::KIND_W-1:0] s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // side_mask, zero padding
    output logic [7:0]                  m_axis_tdata
);

    localparam int NA = bpsc_pkg::NUM_AXES;

    logic [NA-1:0][COORD_BITS-1:0]   w_norm;
    logic [NA-1:0][COORD_BITS-1:0]   w_min;
    logic [NA-1:0][COORD_BITS-1:0]   w_max;
    logic [COORD_BITS-1:0]           w_dist;

    logic                            w_sel_valid;
    logic [NA-1:0][COORD_BITS-1:0]   w_sel_norm;
    logic [NA-1:0][COORD_BITS-1:0]   w_sel_far;
    logic [NA-1:0][COORD_BITS-1:0]   w_sel_near;
    logic [COORD_BITS-1:0]           w_sel_dist;
    logic                            w_sel_axial;
    logic [bpsc_pkg::MASK_W-1:0]     w_sel_mask;

    logic                            w_mul_valid;
    logic [NA-1:0][2*COORD_BITS-1:0] w_far_prod;
    logic [NA-1:0][2*COORD_BITS-1:0] w_near_prod;
    logic [COORD_BITS-1:0]           w_mul_dist;
    logic                            w_mul_axial;
    logic [bpsc_pkg::MASK_W-1:0]     w_mul_mask;

    logic                            w_sum_valid;
    logic                            w_out_valid;
    logic [bpsc_pkg::MASK_W-1:0]     w_out_mask;

    bpsc_pkg::t_pipe_ctl             w_ctl_sel;
    bpsc_pkg::t_pipe_ctl             w_ctl_mul;
    bpsc_pkg::t_pipe_ctl             w_ctl_sum;
    bpsc_pkg::t_pipe_ctl             w_ctl_out;

    // Unpack the input beat
    always_comb begin
        for (int j = 0; j < NA; j++) begin
            w_norm[j] = s_axis_tdata[j*COORD_BITS +: COORD_BITS];
            w_min[j]  = s_axis_tdata[(NA+1+j)*COORD_BITS +: COORD_BITS];
            w_max[j]  = s_axis_tdata[(2*NA+1+j)*COORD_BITS +: COORD_BITS];
        end
        w_dist = s_axis_tdata[NA*COORD_BITS +: COORD_BITS];
    end

    // Stage enables: load when empty or when the next stage takes the beat
    always_comb begin
        w_ctl_out.advance = !w_out_valid || m_axis_tready;
        w_ctl_out.valid   = w_sum_valid;
        w_ctl_sum.advance = !w_sum_valid || w_ctl_out.advance;
        w_ctl_sum.valid   = w_mul_valid;
        w_ctl_mul.advance = !w_mul_valid || w_ctl_sum.advance;
        w_ctl_mul.valid   = w_sel_valid;
        w_ctl_sel.advance = !w_sel_valid || w_ctl_mul.advance;
        w_ctl_sel.valid   = s_axis_tvalid;
    end

    assign s_axis_tready = w_ctl_sel.advance;

    bpsc_select #(
        .COORD_BITS (COORD_BITS)
    ) u_select (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl_sel),
        .i_norm       (w_norm),
        .i_dist       (w_dist),
        .i_kind       (s_axis_tuser),
        .i_min        (w_min),
        .i_max        (w_max),
        .o_valid      (w_sel_valid),
        .o_norm       (w_sel_norm),
        .o_far        (w_sel_far),
        .o_near       (w_sel_near),
        .o_dist       (w_sel_dist),
        .o_axial      (w_sel_axial),
        .o_axial_mask (w_sel_mask)
    );

    bpsc_mult #(
        .COORD_BITS (COORD_BITS)
    ) u_mult (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl_mul),
        .i_norm       (w_sel_norm),
        .i_far        (w_sel_far),
        .i_near       (w_sel_near),
        .i_dist       (w_sel_dist),
        .i_axial      (w_sel_axial),
        .i_axial_mask (w_sel_mask),
        .o_valid      (w_mul_valid),
        .o_far_prod   (w_far_prod),
        .o_near_prod  (w_near_prod),
        .o_dist       (w_mul_dist),
        .o_axial      (w_mul_axial),
        .o_axial_mask (w_mul_mask)
    );

    bpsc_reduce #(
        .COORD_BITS (COORD_BITS)
    ) u_reduce (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl_sum    (w_ctl_sum),
        .i_ctl_out    (w_ctl_out),
        .i_far_prod   (w_far_prod),
        .i_near_prod  (w_near_prod),
        .i_dist       (w_mul_dist),
        .i_axial      (w_mul_axial),
        .i_axial_mask (w_mul_mask),
        .o_sum_valid  (w_sum_valid),
        .o_valid      (w_out_valid),
        .o_mask       (w_out_mask)
    );

    // Drive the output beat
    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {{(8 - bpsc_pkg::MASK_W){1'b0}}, w_out_mask};

endmodule
